### rtl/mrdf_pkg.sv
// mrdf_pkg: shared codes, widths and controller/datapath handshake structs
// for the mesh relay duplicate filter. No dependencies.
`default_nettype none

package mrdf_pkg;

  // item opcodes
  localparam logic [1:0] OP_RECV    = 2'd0;
  localparam logic [1:0] OP_LOCAL   = 2'd1;
  localparam logic [1:0] OP_RELEASE = 2'd2;

  // result status codes
  localparam logic [2:0] ST_QUEUED   = 3'd0;
  localparam logic [2:0] ST_DUP      = 3'd1;
  localparam logic [2:0] ST_HOPLIM   = 3'd2;
  localparam logic [2:0] ST_OWN      = 3'd3;
  localparam logic [2:0] ST_FULL     = 3'd4;
  localparam logic [2:0] ST_RELEASED = 3'd5;
  localparam logic [2:0] ST_IGNORED  = 3'd6;

  // configuration register indexes
  localparam logic REG_NODE_ID  = 1'b0;
  localparam logic REG_MAX_HOPS = 1'b1;

  // field widths
  localparam int NODE_W  = 8;
  localparam int SEQ_W   = 32;
  localparam int HOP_W   = 8;
  localparam int SLOT_W  = 3;
  localparam int COUNT_W = 4;
  localparam int ENTRY_W = NODE_W + SEQ_W;

  // reset values of the configuration registers
  localparam logic [NODE_W-1:0] NODE_ID_RST  = 8'd0;
  localparam logic [HOP_W-1:0]  MAX_HOPS_RST = 8'd5;

  // controller to datapath
  typedef struct packed {
    logic load;        // latch the input item
    logic scan_start;  // rewind cache walk, clear hit flag
    logic scan_step;   // read one cache entry and advance
    logic commit;      // apply the item and load the result register
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic in_recv;     // item at the input is a received header
    logic scan_last;   // walk is at the last cache entry
    logic out_free;    // result register can take a new result
  } sts_t;

endpackage

`default_nettype wire

### rtl/mrdf_ram.sv
// mrdf_ram: generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
`default_nettype none

module mrdf_ram #(
  parameter int WIDTH = 40,
  parameter int DEPTH = 16,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic                   clk,
  input  wire logic                   wr_en,
  input  wire logic [ADDR_W-1:0]      wr_addr,
  input  wire logic [WIDTH-1:0]       wr_data,
  input  wire logic                   rd_en,
  input  wire logic [ADDR_W-1:0]      rd_addr,
  output logic      [WIDTH-1:0]       rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

### rtl/mrdf_ctrl.sv
// mrdf_ctrl: sequencing state machine for the duplicate filter.
// Depends on mrdf_pkg (cmd_t, sts_t).
`default_nettype none

module mrdf_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire mrdf_pkg::sts_t sts,
  output mrdf_pkg::cmd_t     cmd
);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SCAN   = 2'd1;
  localparam logic [1:0] S_DRAIN  = 2'd2;
  localparam logic [1:0] S_COMMIT = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load       = 1'b1;
          cmd.scan_start = 1'b1;
          state_next     = sts.in_recv ? S_SCAN : S_COMMIT;
        end
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (sts.scan_last) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        // last read data is compared this cycle
        state_next = S_COMMIT;
      end
      S_COMMIT: begin
        if (sts.out_free) begin
          cmd.commit = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

### rtl/mrdf_datapath.sv
// mrdf_datapath: item latch, cache RAM walk, queue and sequence counters,
// configuration registers and result register. Depends on mrdf_pkg, mrdf_ram.
`default_nettype none

module mrdf_datapath #(
  parameter int CACHE_DEPTH = 16,
  parameter int QUEUE_DEPTH = 8
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire mrdf_pkg::cmd_t                cmd,
  output mrdf_pkg::sts_t                     sts,
  // configuration
  input  wire logic                          cfg_we,
  input  wire logic                          cfg_index,
  input  wire logic [mrdf_pkg::NODE_W-1:0]   cfg_data,
  // item fields
  input  wire logic [1:0]                    opcode,
  input  wire logic [mrdf_pkg::NODE_W-1:0]   source_node,
  input  wire logic [mrdf_pkg::SEQ_W-1:0]    sequence_number,
  input  wire logic [mrdf_pkg::HOP_W-1:0]    hop_count,
  input  wire logic [mrdf_pkg::SLOT_W-1:0]   release_index,
  // result register
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic      [2:0]                    status,
  output logic                               send_ack,
  output logic      [mrdf_pkg::SLOT_W-1:0]   queue_slot,
  output logic      [mrdf_pkg::SEQ_W-1:0]    assigned_sequence,
  output logic      [mrdf_pkg::COUNT_W-1:0]  queue_count
);

  localparam int IDX_W = (CACHE_DEPTH > 1) ? $clog2(CACHE_DEPTH) : 1;
  localparam int OCC_W = $clog2(QUEUE_DEPTH + 1);
  localparam int CMP_W = (OCC_W > mrdf_pkg::SLOT_W) ? OCC_W : mrdf_pkg::SLOT_W;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CACHE_DEPTH - 1);
  localparam logic [OCC_W-1:0] QUEUE_FULL = OCC_W'(QUEUE_DEPTH);

  // configuration registers
  logic [mrdf_pkg::NODE_W-1:0] node_id;
  logic [mrdf_pkg::HOP_W-1:0]  max_hops;

  // latched item
  logic [1:0]                  op_q;
  logic [mrdf_pkg::NODE_W-1:0] src_q;
  logic [mrdf_pkg::SEQ_W-1:0]  seq_q;
  logic [mrdf_pkg::HOP_W-1:0]  hops_q;
  logic [mrdf_pkg::SLOT_W-1:0] rel_q;

  // cache walk
  logic [IDX_W-1:0]            scan_idx;
  logic [IDX_W-1:0]            cmp_idx;
  logic                        cmp_pend;
  logic                        hit;
  logic [CACHE_DEPTH-1:0]      valid_bits;
  logic [mrdf_pkg::ENTRY_W-1:0] rd_data;

  // persistent counters
  logic [IDX_W-1:0]            wr_ptr;
  logic [OCC_W-1:0]            occ;
  logic [mrdf_pkg::SEQ_W-1:0]  local_seq;

  // commit decisions
  logic                        rec_en;
  logic [mrdf_pkg::NODE_W-1:0] rec_src;
  logic [mrdf_pkg::SEQ_W-1:0]  rec_seq;
  logic                        take_en;
  logic [OCC_W-1:0]            occ_next;
  logic [2:0]                  status_next;
  logic                        ack_next;
  logic [mrdf_pkg::SLOT_W-1:0] slot_next;
  logic [mrdf_pkg::SEQ_W-1:0]  assigned_next;
  logic                        queue_has_room;
  logic                        rel_hit;

  assign sts.in_recv   = (opcode == mrdf_pkg::OP_RECV);
  assign sts.scan_last = (scan_idx == LAST_IDX);
  assign sts.out_free  = !out_valid || out_ready;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      node_id  <= mrdf_pkg::NODE_ID_RST;
      max_hops <= mrdf_pkg::MAX_HOPS_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        mrdf_pkg::REG_NODE_ID:  node_id  <= cfg_data;
        mrdf_pkg::REG_MAX_HOPS: max_hops <= cfg_data;
        default: ;
      endcase
    end
  end

  // item latch
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_q   <= opcode;
      src_q  <= source_node;
      seq_q  <= sequence_number;
      hops_q <= hop_count;
      rel_q  <= release_index;
    end
  end

  // cache RAM: one read a cycle during the walk, one write at commit
  mrdf_ram #(
    .WIDTH (mrdf_pkg::ENTRY_W),
    .DEPTH (CACHE_DEPTH)
  ) u_cache (
    .clk     (clk),
    .wr_en   (rec_en),
    .wr_addr (wr_ptr),
    .wr_data ({rec_src, rec_seq}),
    .rd_en   (cmd.scan_step),
    .rd_addr (scan_idx),
    .rd_data (rd_data)
  );

  // walk counter and hit accumulation, compare in the cycle after the read
  always_ff @(posedge clk) begin
    if (rst) begin
      cmp_pend <= 1'b0;
    end else begin
      cmp_pend <= cmd.scan_step;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_start) begin
      scan_idx <= '0;
      hit      <= 1'b0;
    end else begin
      if (cmd.scan_step) begin
        scan_idx <= scan_idx + 1'b1;
        cmp_idx  <= scan_idx;
      end
      if (cmp_pend && valid_bits[cmp_idx] && (rd_data == {src_q, seq_q})) begin
        hit <= 1'b1;
      end
    end
  end

  // admission decision for the latched item
  assign queue_has_room = (occ < QUEUE_FULL);
  assign rel_hit        = (CMP_W'(rel_q) < CMP_W'(occ));

  always_comb begin
    rec_en        = 1'b0;
    rec_src       = src_q;
    rec_seq       = seq_q;
    take_en       = 1'b0;
    occ_next      = occ;
    status_next   = mrdf_pkg::ST_IGNORED;
    ack_next      = 1'b0;
    slot_next     = '0;
    assigned_next = '0;
    case (op_q)
      mrdf_pkg::OP_RECV: begin
        ack_next = 1'b1;
        if (hit) begin
          status_next = mrdf_pkg::ST_DUP;
        end else if (hops_q >= max_hops) begin
          status_next = mrdf_pkg::ST_HOPLIM;
        end else if (src_q == node_id) begin
          status_next = mrdf_pkg::ST_OWN;
        end else begin
          rec_en  = 1'b1;
          take_en = 1'b1;
        end
      end
      mrdf_pkg::OP_LOCAL: begin
        assigned_next = local_seq;
        rec_en        = 1'b1;
        rec_src       = node_id;
        rec_seq       = local_seq;
        take_en       = 1'b1;
      end
      mrdf_pkg::OP_RELEASE: begin
        if (rel_hit) begin
          occ_next    = occ - 1'b1;
          status_next = mrdf_pkg::ST_RELEASED;
        end
      end
      default: ;
    endcase
    // queue slot for an admitted packet or local reading
    if (take_en) begin
      if (queue_has_room) begin
        slot_next   = mrdf_pkg::SLOT_W'(occ);
        occ_next    = occ + 1'b1;
        status_next = mrdf_pkg::ST_QUEUED;
      end else begin
        status_next = mrdf_pkg::ST_FULL;
      end
    end
    rec_en = rec_en && cmd.commit;
  end

  // state updates at commit
  always_ff @(posedge clk) begin
    if (rst) begin
      valid_bits <= '0;
      wr_ptr     <= '0;
      occ        <= '0;
      local_seq  <= '0;
    end else if (cmd.commit) begin
      occ <= occ_next;
      if (op_q == mrdf_pkg::OP_LOCAL) begin
        local_seq <= local_seq + 1'b1;
      end
      if (rec_en) begin
        valid_bits[wr_ptr] <= 1'b1;
        wr_ptr <= (wr_ptr == LAST_IDX) ? '0 : wr_ptr + 1'b1;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.commit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      status            <= status_next;
      send_ack          <= ack_next;
      queue_slot        <= slot_next;
      assigned_sequence <= assigned_next;
      queue_count       <= mrdf_pkg::COUNT_W'(occ_next);
    end
  end

endmodule

`default_nettype wire

### rtl/mesh_relay_duplicate_filter.sv
// mesh_relay_duplicate_filter: top level, controller plus datapath.
// Depends on mrdf_pkg, mrdf_ctrl, mrdf_datapath (and mrdf_ram below it).
//
// Usage:
//   in channel  (in_valid/in_ready): one item per handshake; opcode selects a
//     received header, a local reading or a queue slot release.
//   out channel (out_valid/out_ready): exactly one result item per input item,
//     in order, held in an output register.
//   cfg channel (cfg_valid/cfg_ready): index 0 node_id, index 1 max_hops;
//     always ready, write only while no item is in flight.
// Sequencing: a received header walks the cache RAM one entry per cycle, then
//   passes a drain step and the commit step before the next item is accepted;
//   other opcodes go from acceptance straight to the commit step. The result is
//   visible the cycle after the commit step.
// Reset clears the cache valid bits, write pointer, queue occupancy, local
//   sequence counter and the output valid flag; node_id returns to 0 and
//   max_hops to 5. No clearing pass is needed.
// Receiver stall: the next item is still accepted and processed while a
//   result waits; the block holds at its commit step until the output
//   register is free.
`default_nettype none

module mesh_relay_duplicate_filter #(
  parameter int CACHE_DEPTH = 16,
  parameter int QUEUE_DEPTH = 8
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // configuration
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic        cfg_index,
  input  wire logic [7:0]  cfg_data,
  // item input
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  opcode,
  input  wire logic [7:0]  source_node,
  input  wire logic [31:0] sequence_number,
  input  wire logic [7:0]  hop_count,
  input  wire logic [2:0]  release_index,
  // result output
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic      [2:0]  status,
  output logic             send_ack,
  output logic      [2:0]  queue_slot,
  output logic      [31:0] assigned_sequence,
  output logic      [3:0]  queue_count
);

  mrdf_pkg::cmd_t cmd;
  mrdf_pkg::sts_t sts;

  assign cfg_ready = 1'b1;

  // sequencing
  mrdf_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // storage and decisions
  mrdf_datapath #(
    .CACHE_DEPTH (CACHE_DEPTH),
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_dp (
    .clk               (clk),
    .rst               (rst),
    .cmd               (cmd),
    .sts               (sts),
    .cfg_we            (cfg_valid && cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .opcode            (opcode),
    .source_node       (source_node),
    .sequence_number   (sequence_number),
    .hop_count         (hop_count),
    .release_index     (release_index),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .status            (status),
    .send_ack          (send_ack),
    .queue_slot        (queue_slot),
    .assigned_sequence (assigned_sequence),
    .queue_count       (queue_count)
  );

  // a queued item leaves the count one above its slot
  a_slot_count: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == mrdf_pkg::ST_QUEUED) |->
      (queue_count[2:0] == queue_slot + 3'd1))
    else $error("queued result count does not follow slot");

  // ack only on received-header outcomes
  a_ack_status: assert property (@(posedge clk) disable iff (rst)
    (out_valid && send_ack) |->
      (status != mrdf_pkg::ST_RELEASED && status != mrdf_pkg::ST_IGNORED))
    else $error("ack on a non-header result");

  // a sequence is assigned only to local readings, which never ack
  a_seq_local: assert property (@(posedge clk) disable iff (rst)
    (out_valid && assigned_sequence != 32'd0) |->
      (!send_ack && (status == mrdf_pkg::ST_QUEUED || status == mrdf_pkg::ST_FULL)))
    else $error("assigned sequence on a non-local result");

endmodule

`default_nettype wire

### sim/mrdf_checker.sv
// mrdf_checker: watches the config, item and result channels of the duplicate
// filter, predicts every result and compares it field by field.
// Depends on mrdf_pkg.
`default_nettype none

module mrdf_checker #(
  parameter int CACHE_ENTRIES = 16,
  parameter int QUEUE_SLOTS   = 8
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_valid,
  input  wire logic        cfg_ready,
  input  wire logic        cfg_index,
  input  wire logic [7:0]  cfg_data,
  input  wire logic        in_valid,
  input  wire logic        in_ready,
  input  wire logic [1:0]  opcode,
  input  wire logic [7:0]  source_node,
  input  wire logic [31:0] sequence_number,
  input  wire logic [7:0]  hop_count,
  input  wire logic [2:0]  release_index,
  input  wire logic        out_valid,
  input  wire logic        out_ready,
  input  wire logic [2:0]  status,
  input  wire logic        send_ack,
  input  wire logic [2:0]  queue_slot,
  input  wire logic [31:0] assigned_sequence,
  input  wire logic [3:0]  queue_count,
  output int               mismatches,
  output int               verdicts_waiting
);

  import mrdf_pkg::*;

  typedef struct packed {
    logic [2:0]  status;
    logic        ack;
    logic [2:0]  slot;
    logic [31:0] assigned;
    logic [3:0]  count;
  } verdict_t;

  // shadow copy of the filter state and registers
  logic [7:0]  id_src  [CACHE_ENTRIES];
  logic [31:0] id_seq  [CACHE_ENTRIES];
  logic        id_live [CACHE_ENTRIES];
  int          id_wr_ptr;
  logic [3:0]  occupancy;
  logic [31:0] next_local_seq;
  logic [7:0]  my_node;
  logic [7:0]  hop_limit;

  verdict_t    expected_verdicts[$];
  int          results_seen;

  initial begin
    mismatches       = 0;
    verdicts_waiting = 0;
    results_seen     = 0;
  end

  // store an identifier at the cache write pointer, wrapping over the oldest
  function automatic void remember_id(input logic [7:0] src, input logic [31:0] seq);
    id_src[id_wr_ptr]  = src;
    id_seq[id_wr_ptr]  = seq;
    id_live[id_wr_ptr] = 1'b1;
    id_wr_ptr = (id_wr_ptr + 1) % CACHE_ENTRIES;
  endfunction

  // take the next free queue slot or report the queue full
  function automatic verdict_t with_slot(input verdict_t v);
    verdict_t r;
    r = v;
    if (occupancy >= QUEUE_SLOTS) begin
      r.status = ST_FULL;
    end else begin
      r.status  = ST_QUEUED;
      r.slot    = occupancy[2:0];
      occupancy = occupancy + 4'd1;
    end
    return r;
  endfunction

  // admission decision for one item, updating the shadow state
  function automatic verdict_t admit_item(input logic [1:0] op, input logic [7:0] src,
                                          input logic [31:0] seq, input logic [7:0] hops,
                                          input logic [2:0] rel);
    verdict_t v;
    logic     hit;
    v        = '0;
    v.status = ST_IGNORED;
    hit      = 1'b0;
    case (op)
      OP_RECV: begin
        v.ack = 1'b1;
        for (int i = 0; i < CACHE_ENTRIES; i++)
          if (id_live[i] && id_src[i] == src && id_seq[i] == seq) hit = 1'b1;
        if (hit) begin
          v.status = ST_DUP;
        end else if (hops >= hop_limit) begin
          v.status = ST_HOPLIM;
        end else if (src == my_node) begin
          v.status = ST_OWN;
        end else begin
          remember_id(src, seq);
          v = with_slot(v);
        end
      end
      OP_LOCAL: begin
        v.assigned     = next_local_seq;
        next_local_seq = next_local_seq + 32'd1;
        remember_id(my_node, v.assigned);
        v = with_slot(v);
      end
      OP_RELEASE: begin
        if ({1'b0, rel} < occupancy) begin
          occupancy = occupancy - 4'd1;
          v.status  = ST_RELEASED;
        end
      end
      default: ;
    endcase
    v.count = occupancy;
    return v;
  endfunction

  task automatic flag_mismatch(input string what);
    mismatches++;
    $display("MISMATCH result %0d: %s", results_seen, what);
  endtask

  // track registers, check results, queue up predictions
  always @(posedge clk) begin
    verdict_t want;
    if (rst) begin
      for (int i = 0; i < CACHE_ENTRIES; i++) begin
        id_src[i]  = '0;
        id_seq[i]  = '0;
        id_live[i] = 1'b0;
      end
      id_wr_ptr      = 0;
      occupancy      = '0;
      next_local_seq = '0;
      my_node        = NODE_ID_RST;
      hop_limit      = MAX_HOPS_RST;
      expected_verdicts.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_NODE_ID) my_node = cfg_data;
        else hop_limit = cfg_data;
      end
      if (out_valid && out_ready) begin
        if (expected_verdicts.size() == 0) begin
          flag_mismatch("result with no item waiting");
        end else begin
          want = expected_verdicts.pop_front();
          if (status !== want.status)
            flag_mismatch($sformatf("status got %0d want %0d", status, want.status));
          if (send_ack !== want.ack)
            flag_mismatch($sformatf("send_ack got %0d want %0d", send_ack, want.ack));
          if (queue_slot !== want.slot)
            flag_mismatch($sformatf("queue_slot got %0d want %0d", queue_slot, want.slot));
          if (assigned_sequence !== want.assigned)
            flag_mismatch($sformatf("assigned_sequence got %0h want %0h",
                                    assigned_sequence, want.assigned));
          if (queue_count !== want.count)
            flag_mismatch($sformatf("queue_count got %0d want %0d", queue_count, want.count));
        end
        results_seen++;
      end
      if (in_valid && in_ready)
        expected_verdicts.push_back(admit_item(opcode, source_node, sequence_number,
                                               hop_count, release_index));
    end
    verdicts_waiting <= expected_verdicts.size();
  end

endmodule

`default_nettype wire

### sim/tb_top.sv
// tb_top: stimulus for mesh_relay_duplicate_filter with random idling and stalls.
// Depends on mrdf_pkg, the filter RTL and mrdf_checker, which does all checking.
`default_nettype none

module tb_top;

  import mrdf_pkg::*;

  localparam logic [1:0] OP_SPARE    = 2'd3;
  localparam int         ITEMS_PHASE = 250;
  localparam int         PHASES      = 6;
  localparam int         HOLD_CYCLES = 300;
  localparam int         HIST_LEN    = 32;

  typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_index = 1'b0;
  logic [7:0]  cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  opcode = '0;
  logic [7:0]  source_node = '0;
  logic [31:0] sequence_number = '0;
  logic [7:0]  hop_count = '0;
  logic [2:0]  release_index = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [2:0]  status;
  logic        send_ack;
  logic [2:0]  queue_slot;
  logic [31:0] assigned_sequence;
  logic [3:0]  queue_count;
  int          mismatches;
  int          verdicts_waiting;

  idle_mode_t  idle_mode = IDLE_NONE;
  logic        hold_req = 1'b0;
  logic        hold_seen = 1'b0;
  int          hold_left = 0;

  // stimulus bookkeeping: current registers and recently sent identifiers
  logic [7:0]  cur_node = NODE_ID_RST;
  logic [7:0]  cur_hops = MAX_HOPS_RST;
  logic [31:0] locals_sent = '0;
  logic [7:0]  hist_src[HIST_LEN];
  logic [31:0] hist_seq[HIST_LEN];
  int          hist_n = 0;
  int          hist_wr = 0;

  always #5 clk = ~clk;

  mesh_relay_duplicate_filter u_dut (
    .clk               (clk),
    .rst               (rst),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .opcode            (opcode),
    .source_node       (source_node),
    .sequence_number   (sequence_number),
    .hop_count         (hop_count),
    .release_index     (release_index),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .status            (status),
    .send_ack          (send_ack),
    .queue_slot        (queue_slot),
    .assigned_sequence (assigned_sequence),
    .queue_count       (queue_count)
  );

  mrdf_checker u_checker (
    .clk               (clk),
    .rst               (rst),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .opcode            (opcode),
    .source_node       (source_node),
    .sequence_number   (sequence_number),
    .hop_count         (hop_count),
    .release_index     (release_index),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .status            (status),
    .send_ack          (send_ack),
    .queue_slot        (queue_slot),
    .assigned_sequence (assigned_sequence),
    .queue_count       (queue_count),
    .mismatches        (mismatches),
    .verdicts_waiting  (verdicts_waiting)
  );

  // result side ready: long hold on request, else random stalls per mode
  always @(negedge clk) begin
    if (hold_seen != hold_req) begin
      hold_seen = hold_req;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (idle_mode == IDLE_RECEIVER) begin
      out_ready <= ($urandom_range(99) >= 88);
    end else if (idle_mode == IDLE_BOTH) begin
      out_ready <= ($urandom_range(99) >= 36);
    end else begin
      out_ready <= 1'b1;
    end
  end

  // run ends here if the block hangs
  initial begin
    #8_000_000;
    $display("Verification failed");
    $finish;
  end

  task automatic write_reg(input logic idx, input logic [7:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // drop valid and wait for every outstanding result
  task automatic drain;
    @(negedge clk);
    in_valid <= 1'b0;
    while (verdicts_waiting != 0) @(negedge clk);
  endtask

  // offer one item after a random gap and wait for its handshake
  task automatic send_item(input logic [1:0] op, input logic [7:0] src,
                           input logic [31:0] seq, input logic [7:0] hops,
                           input logic [2:0] rel);
    int pct;
    pct = (idle_mode == IDLE_SENDER) ? 88 : (idle_mode == IDLE_BOTH) ? 36 : 0;
    while ($urandom_range(99) < pct) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid        <= 1'b1;
    opcode          <= op;
    source_node     <= src;
    sequence_number <= seq;
    hop_count       <= hops;
    release_index   <= rel;
    do @(posedge clk); while (!in_ready);
    // remember identifiers so later headers can repeat them
    if (op == OP_RECV || op == OP_LOCAL) begin
      hist_src[hist_wr] = (op == OP_LOCAL) ? cur_node : src;
      hist_seq[hist_wr] = (op == OP_LOCAL) ? locals_sent : seq;
      hist_wr = (hist_wr + 1) % HIST_LEN;
      if (hist_n < HIST_LEN) hist_n++;
    end
    if (op == OP_LOCAL) locals_sent = locals_sent + 32'd1;
  endtask

  // items of every opcode; headers mix in repeats, own-source and hop-limit
  task automatic send_random;
    int          r;
    int          k;
    logic [1:0]  op;
    logic [7:0]  src;
    logic [31:0] seq;
    logic [7:0]  hops;
    logic [2:0]  rel;
    r    = $urandom_range(99);
    op   = (r < 45) ? OP_RECV : (r < 65) ? OP_LOCAL : (r < 95) ? OP_RELEASE : OP_SPARE;
    src  = 8'($urandom_range(255));
    seq  = $urandom;
    hops = 8'($urandom_range(255));
    rel  = 3'($urandom_range(7));
    if (op == OP_RECV) begin
      r = $urandom_range(99);
      if (r < 30 && hist_n > 0) begin
        k   = $urandom_range(hist_n - 1);
        src = hist_src[k];
        seq = hist_seq[k];
      end else begin
        if (r < 40) src = cur_node;
        if ($urandom_range(1)) seq = $urandom_range(15);
      end
      if (cur_hops != 0 && $urandom_range(99) < 80) hops = 8'($urandom_range(cur_hops - 1));
    end
    send_item(op, src, seq, hops, rel);
  endtask

  initial begin
    logic [7:0] phase_node[PHASES];
    logic [7:0] phase_hops[PHASES];
    idle_mode_t phase_mode[PHASES];
    int         waited;

    phase_node = '{8'hFF, 8'h00, 8'hA5, 8'h00, 8'h5A, 8'h00};
    phase_hops = '{8'd0, 8'hFF, 8'd8, 8'd0, 8'd3, 8'd0};
    phase_mode = '{IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH, IDLE_NONE,
                   IDLE_RECEIVER};
    phase_node[3] = 8'($urandom_range(255));
    phase_hops[3] = 8'($urandom_range(1, 16));
    phase_node[5] = 8'($urandom_range(255));
    phase_hops[5] = 8'($urandom_range(255));

    repeat (10) @(negedge clk);
    rst <= 1'b0;

    // directed: reset registers, node 0 and hop limit 5
    send_item(OP_RECV, 8'h00, 32'h0000_0001, 8'd0, 3'd0);    // own source
    send_item(OP_RECV, 8'hFF, 32'hFFFF_FFFF, 8'd4, 3'd7);    // queued
    send_item(OP_RECV, 8'hFF, 32'hFFFF_FFFF, 8'd4, 3'd0);    // duplicate
    send_item(OP_RECV, 8'h01, 32'h0000_0000, 8'd5, 3'd0);    // hop limit edge
    send_item(OP_RECV, 8'h02, 32'h0000_0000, 8'hFF, 3'd0);   // hop limit max
    send_item(OP_LOCAL, 8'h00, 32'h0, 8'd0, 3'd0);
    send_item(OP_RELEASE, 8'h00, 32'h0, 8'd0, 3'd7);         // out of range
    send_item(OP_RELEASE, 8'h00, 32'h0, 8'd0, 3'd1);
    send_item(OP_SPARE, 8'hFF, 32'hFFFF_FFFF, 8'hFF, 3'd7);  // unused opcode
    // fill the queue with local readings, last ones find it full
    repeat (9) send_item(OP_LOCAL, 8'h00, 32'h0, 8'd0, 3'd0);
    send_item(OP_RECV, 8'h03, 32'h8000_0000, 8'd0, 3'd0);    // full but recorded
    send_item(OP_RECV, 8'h03, 32'h8000_0000, 8'd0, 3'd0);    // duplicate of it
    send_item(OP_RELEASE, 8'h00, 32'h0, 8'd0, 3'd0);
    send_item(OP_RECV, 8'h00, 32'h0000_0000, 8'd0, 3'd0);    // matches a local reading
    send_item(OP_RELEASE, 8'h00, 32'h0, 8'd0, 3'd7);
    // enough new identifiers to wrap the cache, then the first recorded header again
    for (int i = 0; i < 17; i++) begin
      send_item(OP_RECV, 8'(8'h40 + i), 32'(32'h100 + i), 8'd0, 3'd0);
      send_item(OP_RELEASE, 8'h00, 32'h0, 8'd0, 3'd0);
    end
    send_item(OP_RECV, 8'hFF, 32'hFFFF_FFFF, 8'd4, 3'd0);    // evicted, no longer duplicate

    // random phases, each under its own register setting and idling mode
    for (int ph = 0; ph < PHASES; ph++) begin
      drain();
      write_reg(REG_NODE_ID, phase_node[ph]);
      write_reg(REG_MAX_HOPS, phase_hops[ph]);
      cur_node  = phase_node[ph];
      cur_hops  = phase_hops[ph];
      idle_mode = phase_mode[ph];
      for (int n = 0; n < ITEMS_PHASE; n++) begin
        // long result hold while items keep coming
        if (ph == 0 && n == 100) hold_req = !hold_req;
        if (ph == 4 && n == 60) hold_req = !hold_req;
        // sender waits for every result before going on
        if (ph == 1 && n == 125) drain();
        send_random();
      end
    end

    @(negedge clk);
    in_valid <= 1'b0;
    waited = 0;
    while (verdicts_waiting != 0 && waited < 50000) begin
      @(negedge clk);
      waited++;
    end
    repeat (40) @(negedge clk);
    if (mismatches == 0 && verdicts_waiting == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

### mesh_relay_duplicate_filter.f
rtl/mrdf_pkg.sv
rtl/mrdf_ram.sv
rtl/mrdf_ctrl.sv
rtl/mrdf_datapath.sv
rtl/mesh_relay_duplicate_filter.sv
sim/mrdf_checker.sv
sim/tb_top.sv
